>>> design/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the Bresenham line stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  // Width of the RGBA colour carried with every pixel
  localparam int unsigned COLOR_W = 32;

  // Request kind, carried on the slave tuser
  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  // Per-line control flags held between requests
  typedef struct packed {
    logic active;
    logic steep;
    logic step_down;
  } line_flags_t;

endpackage

`default_nettype wire

>>> design/bls_step.sv
// ----------------------------------------------------------------------------
// bls_step
// Single-pass step logic: sets up a new line on a start request or advances
// the current line by one pixel on a tick, and gives the next line state.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_step #(
  parameter int unsigned COORD_BITS = 12
) (
  // request
  input  var bls_pkg::op_e          op_i,
  input  var logic [COORD_BITS-1:0] start_x_i,
  input  var logic [COORD_BITS-1:0] start_y_i,
  input  var logic [COORD_BITS-1:0] end_x_i,
  input  var logic [COORD_BITS-1:0] end_y_i,
  // current line state
  input  var bls_pkg::line_flags_t  flags_q_i,
  input  var logic [COORD_BITS-1:0] major_pos_q_i,
  input  var logic [COORD_BITS-1:0] major_end_q_i,
  input  var logic [COORD_BITS-1:0] minor_pos_q_i,
  input  var logic [COORD_BITS:0]   major_delta_q_i,
  input  var logic [COORD_BITS+1:0] err_inc_q_i,
  input  var logic [COORD_BITS+3:0] err_acc_q_i,
  // result
  output var logic                  emit_o,
  output var logic                  last_o,
  output var logic [COORD_BITS-1:0] pixel_x_o,
  output var logic [COORD_BITS-1:0] pixel_y_o,
  // next line state
  output var bls_pkg::line_flags_t  flags_d_o,
  output var logic [COORD_BITS-1:0] major_pos_d_o,
  output var logic [COORD_BITS-1:0] major_end_d_o,
  output var logic [COORD_BITS-1:0] minor_pos_d_o,
  output var logic [COORD_BITS:0]   major_delta_d_o,
  output var logic [COORD_BITS+1:0] err_inc_d_o,
  output var logic [COORD_BITS+3:0] err_acc_d_o
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned ERRW = COORD_BITS + 4;

  // start setup
  logic signed [CW:0]   sx_ext, sy_ext, ex_ext, ey_ext;
  logic signed [CW:0]   dx, dy;
  logic        [CW:0]   adx, ady;
  logic                 steep;
  logic signed [CW-1:0] a_maj, a_min, b_maj, b_min;
  logic signed [CW-1:0] lo_maj, lo_min, hi_maj, hi_min;
  logic signed [CW:0]   dmin;
  logic        [CW:0]   admin;

  // state the emit works on
  bls_pkg::line_flags_t  cur_flags;
  logic signed [CW-1:0]  cur_maj, cur_end, cur_min;
  logic        [CW:0]    cur_delta;
  logic        [CW+1:0]  cur_inc;
  logic signed [ERRW-1:0] cur_acc;

  // emit update
  logic signed [ERRW-1:0] acc_sum, delta_ext;
  logic                   minor_step;

  // Sign-extend endpoints and take axis distances
  always_comb begin
    sx_ext = {start_x_i[CW-1], start_x_i};
    sy_ext = {start_y_i[CW-1], start_y_i};
    ex_ext = {end_x_i[CW-1], end_x_i};
    ey_ext = {end_y_i[CW-1], end_y_i};
    dx     = ex_ext - sx_ext;
    dy     = ey_ext - sy_ext;
    adx    = dx[CW] ? (CW+1)'(1) + (CW+1)'(~dx) : dx;
    ady    = dy[CW] ? (CW+1)'(1) + (CW+1)'(~dy) : dy;
    steep  = adx < ady;
  end

  // Transpose steep lines, then order endpoints along the major axis
  always_comb begin
    if (steep) begin
      a_maj = start_y_i; a_min = start_x_i; b_maj = end_y_i; b_min = end_x_i;
    end else begin
      a_maj = start_x_i; a_min = start_y_i; b_maj = end_x_i; b_min = end_y_i;
    end
    if (a_maj > b_maj) begin
      lo_maj = b_maj; lo_min = b_min; hi_maj = a_maj; hi_min = a_min;
    end else begin
      lo_maj = a_maj; lo_min = a_min; hi_maj = b_maj; hi_min = b_min;
    end
    dmin  = {hi_min[CW-1], hi_min} - {lo_min[CW-1], lo_min};
    admin = dmin[CW] ? (CW+1)'(1) + (CW+1)'(~dmin) : dmin;
  end

  // Pick fresh setup on a start, held state on a tick
  always_comb begin
    if (op_i == bls_pkg::OP_START) begin
      cur_flags.active    = 1'b1;
      cur_flags.steep     = steep;
      cur_flags.step_down = !(hi_min > lo_min);
      cur_maj             = lo_maj;
      cur_end             = hi_maj;
      cur_min             = lo_min;
      cur_delta           = {hi_maj[CW-1], hi_maj} - {lo_maj[CW-1], lo_maj};
      cur_inc             = {admin, 1'b0};
      cur_acc             = '0;
    end else begin
      cur_flags = flags_q_i;
      cur_maj   = major_pos_q_i;
      cur_end   = major_end_q_i;
      cur_min   = minor_pos_q_i;
      cur_delta = major_delta_q_i;
      cur_inc   = err_inc_q_i;
      cur_acc   = err_acc_q_i;
    end
  end

  // Emit the pixel and advance the error term
  always_comb begin
    emit_o    = cur_flags.active;
    last_o    = cur_maj >= cur_end;
    pixel_x_o = cur_flags.steep ? cur_min : cur_maj;
    pixel_y_o = cur_flags.steep ? cur_maj : cur_min;

    acc_sum    = cur_acc + ERRW'(cur_inc);
    delta_ext  = ERRW'(cur_delta);
    minor_step = acc_sum > delta_ext;

    flags_d_o       = cur_flags;
    major_end_d_o   = cur_end;
    major_delta_d_o = cur_delta;
    err_inc_d_o     = cur_inc;
    major_pos_d_o   = cur_maj;
    minor_pos_d_o   = cur_min;
    err_acc_d_o     = cur_acc;

    if (cur_flags.active) begin
      if (last_o) begin
        // drop the line after its final pixel
        flags_d_o.active = 1'b0;
      end else begin
        major_pos_d_o = cur_maj + CW'(1);
        if (minor_step) begin
          minor_pos_d_o = cur_flags.step_down ? cur_min - CW'(1) : cur_min + CW'(1);
          err_acc_d_o   = acc_sum - (delta_ext <<< 1);
        end else begin
          err_acc_d_o   = acc_sum;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer Bresenham line rasteriser with stream request and pixel ports.
// ----------------------------------------------------------------------------
// A start request (tuser = 0) loads two endpoints and a colour and produces
// the first pixel of the line; each tick request (tuser = 1) produces the
// next pixel, with tlast set on the final one. A tick with no line in
// progress produces nothing, and a start abandons any line in progress.
// The block takes one request per cycle unless a waiting pixel is held back,
// and the pixel appears in the output register on the cycle after the request
// is taken; the error update and coordinate step are combinational, from the
// line state registers to the output register. The request side stays ready
// while a pixel waits, as long as that pixel is taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_stepper #(
  parameter int unsigned COORD_BITS = 12
) (
  input  var logic clk_i,
  input  var logic rst_ni,

  // request stream
  input  var logic                              s_axis_tvalid,
  output var logic                              s_axis_tready,
  // tdata, low bit up: start_x, start_y, end_x, end_y, color, zero fill
  input  var logic [((4*COORD_BITS+32+7)/8)*8-1:0] s_axis_tdata,
  // tuser: op
  input  var logic [0:0]                        s_axis_tuser,

  // pixel stream
  output var logic                              m_axis_tvalid,
  input  var logic                              m_axis_tready,
  // tdata, low bit up: pixel_x, pixel_y, pixel_color, zero fill
  output var logic [((2*COORD_BITS+32+7)/8)*8-1:0] m_axis_tdata,
  output var logic                              m_axis_tlast
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned ERRW  = COORD_BITS + 4;
  localparam int unsigned COLW  = bls_pkg::COLOR_W;
  localparam int unsigned OUTW  = ((2*COORD_BITS+32+7)/8)*8;

  logic accept;

  // line state
  bls_pkg::line_flags_t flags_q, flags_d;
  logic [CW-1:0]   major_pos_q, major_pos_d;
  logic [CW-1:0]   major_end_q, major_end_d;
  logic [CW-1:0]   minor_pos_q, minor_pos_d;
  logic [CW:0]     major_delta_q, major_delta_d;
  logic [CW+1:0]   err_inc_q, err_inc_d;
  logic [ERRW-1:0] err_acc_q, err_acc_d;
  logic [COLW-1:0] color_q;

  // step results
  logic          emit;
  logic          last;
  logic [CW-1:0] pixel_x, pixel_y;

  // output register
  logic            out_valid_q;
  logic            out_last_q;
  logic [CW-1:0]   out_x_q, out_y_q;
  logic [COLW-1:0] out_color_q;

  bls_pkg::op_e op;
  logic [COLW-1:0] in_color;

  assign op       = bls_pkg::op_e'(s_axis_tuser[0]);
  assign in_color = s_axis_tdata[4*CW +: COLW];

  // Take a request whenever the output register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bls_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .op_i            (op),
    .start_x_i       (s_axis_tdata[0    +: CW]),
    .start_y_i       (s_axis_tdata[CW   +: CW]),
    .end_x_i         (s_axis_tdata[2*CW +: CW]),
    .end_y_i         (s_axis_tdata[3*CW +: CW]),
    .flags_q_i       (flags_q),
    .major_pos_q_i   (major_pos_q),
    .major_end_q_i   (major_end_q),
    .minor_pos_q_i   (minor_pos_q),
    .major_delta_q_i (major_delta_q),
    .err_inc_q_i     (err_inc_q),
    .err_acc_q_i     (err_acc_q),
    .emit_o          (emit),
    .last_o          (last),
    .pixel_x_o       (pixel_x),
    .pixel_y_o       (pixel_y),
    .flags_d_o       (flags_d),
    .major_pos_d_o   (major_pos_d),
    .major_end_d_o   (major_end_d),
    .minor_pos_d_o   (minor_pos_d),
    .major_delta_d_o (major_delta_d),
    .err_inc_d_o     (err_inc_d),
    .err_acc_d_o     (err_acc_d)
  );

  // Hold line state; advance it on every accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      major_delta_q <= '0;
      err_inc_q     <= '0;
      err_acc_q     <= '0;
      color_q       <= '0;
    end else if (accept) begin
      flags_q       <= flags_d;
      major_pos_q   <= major_pos_d;
      major_end_q   <= major_end_d;
      minor_pos_q   <= minor_pos_d;
      major_delta_q <= major_delta_d;
      err_inc_q     <= err_inc_d;
      err_acc_q     <= err_acc_d;
      if (op == bls_pkg::OP_START) begin
        color_q <= in_color;
      end
    end
  end

  // Output valid: load on an emitting request, clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_last_q  <= last;
      out_x_q     <= pixel_x;
      out_y_q     <= pixel_y;
      out_color_q <= (op == bls_pkg::OP_START) ? in_color : color_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUTW'({out_color_q, out_y_q, out_x_q});

endmodule

`default_nettype wire

>>> verif/bresenham_line_stepper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_stepper_tb
// Self-checking bench for the Bresenham line stepper.
// ----------------------------------------------------------------------------
// Start and tick requests go in on the request stream. Every request that is
// taken is run through a behavioural line rasteriser kept inside the bench,
// and the pixel it yields is queued. Pixels leaving the block are checked
// field by field against that queue. A short directed table covers the
// corner cases: tick with no line, single-pixel line, extreme and reversed
// endpoints, steep lines, diagonal lines and abandoned lines. Random lines
// follow, under three patterns of idling on both streams and one long hold
// on the pixel side.
// ----------------------------------------------------------------------------

module bresenham_line_stepper_tb;

  localparam int CW    = 12;
  localparam int REQ_W = ((4*CW+32+7)/8)*8;
  localparam int PIX_W = ((2*CW+32+7)/8)*8;
  localparam int N_DIR = 25;

  typedef struct packed {
    logic [CW-1:0]               x;
    logic [CW-1:0]               y;
    logic [bls_pkg::COLOR_W-1:0] color;
    logic                        last;
  } pixel_t;

  typedef struct {
    bls_pkg::op_e                op;
    int                          sx;
    int                          sy;
    int                          ex;
    int                          ey;
    logic [bls_pkg::COLOR_W-1:0] col;
    bit                          typed;
    pixel_t                      want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [REQ_W-1:0] s_axis_tdata = '0;
  logic [0:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  // Line state of the behavioural rasteriser
  bit                          ln_active;
  bit                          ln_steep;
  bit                          ln_minor_down;
  int                          ln_maj_pos;
  int                          ln_maj_end;
  int                          ln_min_pos;
  int                          ln_maj_delta;
  int                          ln_err_inc;
  int                          ln_err_acc;
  logic [bls_pkg::COLOR_W-1:0] ln_color;

  pixel_t pending_pixels[$];
  int     tx_idle_pct;
  int     rx_idle_pct;
  bit     hold_pixels;
  int     pixels_requested;
  int     pixels_checked;
  int     lines_started;
  int     steep_lines;
  int     idle_ticks;
  int     mismatches;

  dir_row_t dir_tab [N_DIR] = '{
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_START,     5,     5,    5,    5, 32'hFFFF_FFFF, 1'b1,
      '{12'h005, 12'h005, 32'hFFFF_FFFF, 1'b1}},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_START, -2048, -2048, 2047, 2047, 32'h0,        1'b1,
      '{12'h800, 12'h800, 32'h0, 1'b0}},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_START,  2047, -2048, -2048, 2047, 32'hA5A5_A5A5, 1'b1,
      '{12'h800, 12'h7FF, 32'hA5A5_A5A5, 1'b0}},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_START,     0,     0,    3,   10, 32'h5A5A_5A5A, 1'b1,
      '{12'h000, 12'h000, 32'h5A5A_5A5A, 1'b0}},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_START,     7,    -3,    4,  -12, 32'h1234_5678, 1'b1,
      '{12'h004, 12'hFF4, 32'h1234_5678, 1'b0}},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0},
    '{bls_pkg::OP_TICK,      0,     0,    0,    0, 32'h0,        1'b0, '0}
  };

  bresenham_line_stepper #(
    .COORD_BITS(CW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic int abs_dist(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic logic [REQ_W-1:0] rand_req_bits();
    return REQ_W'({$urandom, $urandom, $urandom});
  endfunction

  function automatic logic [REQ_W-1:0] pack_start(input int ax, input int ay, input int bx,
                                                  input int by,
                                                  input logic [bls_pkg::COLOR_W-1:0] col);
    return REQ_W'({col, by[CW-1:0], bx[CW-1:0], ay[CW-1:0], ax[CW-1:0]});
  endfunction

  // Emit the pixel at the current position, then advance the line by one step
  function automatic pixel_t emit_pixel();
    pixel_t p;
    p.x     = ln_steep ? ln_min_pos[CW-1:0] : ln_maj_pos[CW-1:0];
    p.y     = ln_steep ? ln_maj_pos[CW-1:0] : ln_min_pos[CW-1:0];
    p.color = ln_color;
    p.last  = (ln_maj_pos >= ln_maj_end);
    if (p.last) begin
      ln_active = 1'b0;
      return p;
    end
    ln_err_acc += ln_err_inc;
    if (ln_err_acc > ln_maj_delta) begin
      ln_min_pos += ln_minor_down ? -1 : 1;
      ln_err_acc -= 2 * ln_maj_delta;
    end
    ln_maj_pos += 1;
    return p;
  endfunction

  // Work out the pixel, if any, that one request yields
  function automatic bit rasterise_request(input bls_pkg::op_e op,
                                           input logic [REQ_W-1:0] data,
                                           output pixel_t p);
    int ax, ay, bx, by;
    int a_maj, a_min, b_maj, b_min, t;
    p = '0;
    if (op == bls_pkg::OP_TICK) begin
      if (!ln_active) return 1'b0;
      p = emit_pixel();
      return 1'b1;
    end
    ax = int'($signed(data[CW-1:0]));
    ay = int'($signed(data[2*CW-1:CW]));
    bx = int'($signed(data[3*CW-1:2*CW]));
    by = int'($signed(data[4*CW-1:3*CW]));
    ln_steep = abs_dist(ax, bx) < abs_dist(ay, by);
    if (ln_steep) begin
      a_maj = ay; a_min = ax; b_maj = by; b_min = bx;
    end else begin
      a_maj = ax; a_min = ay; b_maj = bx; b_min = by;
    end
    // order the endpoints so the major axis runs upward
    if (a_maj > b_maj) begin
      t = a_maj; a_maj = b_maj; b_maj = t;
      t = a_min; a_min = b_min; b_min = t;
    end
    ln_maj_pos    = a_maj;
    ln_maj_end    = b_maj;
    ln_min_pos    = a_min;
    ln_minor_down = !(b_min > a_min);
    ln_maj_delta  = b_maj - a_maj;
    ln_err_inc    = 2 * abs_dist(b_min, a_min);
    ln_err_acc    = 0;
    ln_color      = data[4*CW+bls_pkg::COLOR_W-1:4*CW];
    ln_active     = 1'b1;
    lines_started++;
    if (ln_steep) steep_lines++;
    p = emit_pixel();
    return 1'b1;
  endfunction

  // Offer one request; entered and left at a falling edge
  task automatic send_request(input bls_pkg::op_e op, input logic [REQ_W-1:0] data,
                              input bit typed, input pixel_t want);
    pixel_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = rand_req_bits();
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (rasterise_request(op, data, p)) begin
      pending_pixels.push_back(typed ? want : p);
      pixels_requested++;
    end else begin
      idle_ticks++;
    end
    @(negedge clk_i);
  endtask

  // One random line: mostly short well-formed lines run to their end or a
  // little past it, some cut short, some spanning the whole plane
  task automatic draw_random_line();
    int ax, ay, bx, by, span, len, ticks;
    logic [bls_pkg::COLOR_W-1:0] col;
    col = $urandom;
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 3)) send_request(bls_pkg::OP_TICK, rand_req_bits(), 1'b0, '0);
    end
    ax = int'($urandom_range(4095)) - 2048;
    ay = int'($urandom_range(4095)) - 2048;
    if ($urandom_range(7) == 0) begin
      bx    = int'($urandom_range(4095)) - 2048;
      by    = int'($urandom_range(4095)) - 2048;
      ticks = $urandom_range(0, 6);
    end else begin
      case ($urandom_range(3))
        0:       span = 1;
        1:       span = 4;
        2:       span = 16;
        default: span = 48;
      endcase
      bx    = clamp_coord(ax + int'($urandom_range(2 * span)) - span);
      by    = clamp_coord(ay + int'($urandom_range(2 * span)) - span);
      len   = (abs_dist(ax, bx) > abs_dist(ay, by)) ? abs_dist(ax, bx) : abs_dist(ay, by);
      ticks = len + $urandom_range(0, 2);
      if ($urandom_range(5) == 0) ticks = $urandom_range(0, len);
    end
    send_request(bls_pkg::OP_START, pack_start(ax, ay, bx, by, col), 1'b0, '0);
    repeat (ticks) send_request(bls_pkg::OP_TICK, rand_req_bits(), 1'b0, '0);
  endtask

  // Pixel side: random back-pressure, plus one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pixels) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_pixels = 1'b0;
      end
      m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check each pixel taken against the oldest queued one
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    logic [CW-1:0]               got_x;
    logic [CW-1:0]               got_y;
    logic [bls_pkg::COLOR_W-1:0] got_col;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_x   = m_axis_tdata[CW-1:0];
      got_y   = m_axis_tdata[2*CW-1:CW];
      got_col = m_axis_tdata[2*CW+bls_pkg::COLOR_W-1:2*CW];
      if (pending_pixels.size() == 0) begin
        $error("pixel with none pending: x=%0d y=%0d", $signed(got_x), $signed(got_y));
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", $signed(want.x), $signed(got_x));
          mismatches++;
        end
        if (got_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", $signed(want.y), $signed(got_y));
          mismatches++;
        end
        if (got_col !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, got_col);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Reset, directed table, then three phases of random lines
  initial begin
    tx_idle_pct = 15;
    rx_idle_pct = 75;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].op,
                   (dir_tab[i].op == bls_pkg::OP_START) ?
                     pack_start(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex, dir_tab[i].ey,
                                dir_tab[i].col) : '0,
                   dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 15; rx_idle_pct = 75; end
        1:       begin tx_idle_pct = 75; rx_idle_pct = 15; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_pixels = 1'b1;
        end
      endcase
      while (pixels_requested < (ph + 1) * 600) draw_random_line();
    end
    s_axis_tvalid = 1'b0;

    // drain, then wait for any stray pixel
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Lines started: %0d (%0d steep); pixels checked: %0d; idle ticks: %0d",
             lines_started, steep_lines, pixels_checked, idle_ticks);
    $display("Idling patterns: sender-light/receiver-heavy, reversed, none with a long hold");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
